// ===== rtl/bb3_pkg.sv =====
// Shared types, constants and helper functions for the 3x3 box blur stream.
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    localparam int CFG_W     = 13;
    localparam int PIX_W     = 24;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int RECIP_W   = 17;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    // Register indexes of the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Input kinds carried on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // One classified beat handed from the front to the back.
    // For a pixel: row_a = r>=1, row_b = r>=2, col_a = c>=1, col_b = c>=2,
    // col_last = c==w-1. For a drain: row_b = h>=2, col_a = d>=1,
    // col_b = d+1<w, col_last = d==w-1.
    typedef struct packed {
        logic              is_drain;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              row_a;
        logic              row_b;
        logic              col_a;
        logic              col_b;
        logic              col_last;
    } bb3_item_t;

    // Reciprocal scaled by 2^16 for each possible neighbor count
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/bb3_front.sv =====
// Front end: configuration registers, raster counters and beat classification.
module bb3_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [bb3_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_kind,
    input  logic [bb3_pkg::PIX_W-1:0]  in_pix,
    input  logic                       in_take,
    output logic                       push,
    output bb3_pkg::bb3_item_t         push_item
);

    logic [bb3_pkg::WIDTH_W-1:0]  width_reg;
    logic [bb3_pkg::HEIGHT_W-1:0] height_reg;
    logic [bb3_pkg::WIDTH_W-1:0]  col_reg, col_next;
    logic [bb3_pkg::HEIGHT_W-1:0] row_reg, row_next;
    logic [bb3_pkg::WIDTH_W-1:0]  drain_reg, drain_next;
    logic [bb3_pkg::WIDTH_W-1:0]  w_eff;
    logic [bb3_pkg::HEIGHT_W-1:0] h_eff;
    logic [bb3_pkg::WIDTH_W-1:0]  col_inc, drain_inc;
    logic                         pix_ok, drain_ok, is_drain;

    // Clamp the configured frame size to the usable range
    always_comb begin
        if (width_reg == '0) begin
            w_eff = bb3_pkg::WIDTH_W'(1);
        end else if (width_reg > bb3_pkg::WIDTH_W'(bb3_pkg::MAX_WIDTH)) begin
            w_eff = bb3_pkg::WIDTH_W'(bb3_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? bb3_pkg::HEIGHT_W'(1) : height_reg;
    end

    // Classify the beat: pixels inside the frame, drains after it
    assign is_drain  = (in_kind == bb3_pkg::OP_DRAIN);
    assign pix_ok    = !is_drain && (row_reg < h_eff) && (col_reg < w_eff);
    assign drain_ok  = is_drain && (row_reg >= h_eff);
    assign push      = in_valid && in_take && (pix_ok || drain_ok);
    assign col_inc   = col_reg + 1'b1;
    assign drain_inc = drain_reg + 1'b1;

    always_comb begin
        push_item          = '0;
        push_item.is_drain = is_drain;
        push_item.pix      = in_pix;
        if (is_drain) begin
            push_item.addr     = drain_reg[bb3_pkg::ADDR_W-1:0];
            push_item.row_b    = (h_eff >= bb3_pkg::HEIGHT_W'(2));
            push_item.col_a    = (drain_reg >= bb3_pkg::WIDTH_W'(1));
            push_item.col_b    = (drain_inc < w_eff);
            push_item.col_last = (drain_inc == w_eff);
        end else begin
            push_item.addr     = col_reg[bb3_pkg::ADDR_W-1:0];
            push_item.row_a    = (row_reg >= bb3_pkg::HEIGHT_W'(1));
            push_item.row_b    = (row_reg >= bb3_pkg::HEIGHT_W'(2));
            push_item.col_a    = (col_reg >= bb3_pkg::WIDTH_W'(1));
            push_item.col_b    = (col_reg >= bb3_pkg::WIDTH_W'(2));
            push_item.col_last = (col_inc == w_eff);
        end
    end

    // Advance the raster and drain counters
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (cfg_wr_en) begin
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
        end else if (push && !is_drain) begin
            if (col_inc >= w_eff) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_inc;
            end
        end else if (push) begin
            if (drain_inc >= w_eff) begin
                drain_next = '0;
                col_next   = '0;
                row_next   = '0;
            end else begin
                drain_next = drain_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bb3_pkg::WIDTH_W'(640);
            height_reg <= bb3_pkg::HEIGHT_W'(480);
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= '0;
        end else begin
            if (cfg_wr_en && cfg_addr == bb3_pkg::REG_WIDTH) begin
                width_reg <= cfg_wdata[bb3_pkg::WIDTH_W-1:0];
            end
            if (cfg_wr_en && cfg_addr == bb3_pkg::REG_HEIGHT) begin
                height_reg <= cfg_wdata[bb3_pkg::HEIGHT_W-1:0];
            end
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ===== rtl/bb3_queue.sv =====
// Short queue of classified beats between the front and the back.
module bb3_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  bb3_pkg::bb3_item_t push_item,
    output logic               has_room,
    input  logic               pop,
    output logic               q_valid,
    output bb3_pkg::bb3_item_t q_item
);

    bb3_pkg::bb3_item_t         slot_reg [bb3_pkg::Q_DEPTH];
    logic [bb3_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [bb3_pkg::Q_PTR_W:0]   count_reg, count_next;

    assign has_room = (count_reg != (bb3_pkg::Q_PTR_W+1)'(bb3_pkg::Q_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store the beat
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/bb3_back.sv =====
// Back end: line store, 3x3 window, masked sums, rounding divide, output register.
module bb3_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  bb3_pkg::bb3_item_t        q_item,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,
    output logic                      m_tlast,
    output logic                      m_tuser
);

    localparam int LINE_W = 2 * bb3_pkg::PIX_W;

    // Entry holds {upper row, middle row}
    logic [LINE_W-1:0] line_mem [bb3_pkg::MAX_WIDTH];

    logic                        a_valid_reg;
    bb3_pkg::bb3_item_t          a_item_reg;
    logic [LINE_W-1:0]           rd0_reg, rd1_reg;
    logic                        a_adv, b_free, disp, sel;
    logic                        mem_we;
    logic [bb3_pkg::ADDR_W-1:0]  mem_wa, ra0, ra1;
    logic [LINE_W-1:0]           mem_wd;

    logic [bb3_pkg::PIX_W-1:0]   win_reg [9];
    logic [1:0]                  pend_reg;
    logic [8:0]                  mask_reg [2];
    logic [1:0]                  fend_reg, rend_reg;
    logic [1:0]                  ld_pend, ld_fend, ld_rend;
    logic [8:0]                  ld_mask [2];

    logic                        c_valid_reg, c_take;
    logic [bb3_pkg::SUM_W-1:0]   c_sum_reg [3];
    logic [bb3_pkg::CNT_W-1:0]   c_n_reg;
    logic                        c_fend_reg, c_rend_reg;
    logic [bb3_pkg::SUM_W-1:0]   sum_d [3];
    logic [8:0]                  mask_sel;

    logic                        d_take;
    logic [bb3_pkg::SUM_W-1:0]   rnd [3];
    logic [bb3_pkg::PROD_W-1:0]  prod [3];
    logic [bb3_pkg::RECIP_W-1:0] m_recip;

    function automatic logic [8:0] mk_mask(input logic [2:0] rv, input logic [2:0] cv);
        logic [8:0] m;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i*3+j] = rv[i] & cv[j];
            end
        end
        return m;
    endfunction

    // Stage handshakes
    assign d_take = !m_tvalid || m_tready;
    assign c_take = !c_valid_reg || d_take;
    assign disp   = (pend_reg != 2'b00) && c_take;
    assign sel    = !pend_reg[0];
    assign b_free = (pend_reg == 2'b00) ||
                    (disp && (pend_reg == 2'b01 || pend_reg == 2'b10));
    assign a_adv  = a_valid_reg && b_free;
    assign pop    = q_valid && (!a_valid_reg || a_adv);

    // Write back the shifted rows when a pixel leaves the read stage
    assign mem_we = a_adv && !a_item_reg.is_drain;
    assign mem_wa = a_item_reg.addr;
    assign mem_wd = {rd0_reg[bb3_pkg::PIX_W-1:0], a_item_reg.pix};
    assign ra0    = q_item.addr;
    assign ra1    = q_item.addr + 1'b1;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_wa] <= mem_wd;
        end
        if (pop) begin
            rd0_reg <= (mem_we && mem_wa == ra0) ? mem_wd : line_mem[ra0];
            rd1_reg <= (mem_we && mem_wa == ra1) ? mem_wd : line_mem[ra1];
        end
    end

    // Read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pop) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            a_item_reg <= q_item;
        end
    end

    // Build the result jobs of the beat in the read stage
    always_comb begin
        ld_pend    = 2'b00;
        ld_fend    = 2'b00;
        ld_rend    = 2'b00;
        ld_mask[0] = '0;
        ld_mask[1] = '0;
        if (a_item_reg.is_drain) begin
            ld_pend[0] = 1'b1;
            ld_mask[0] = mk_mask({1'b0, 1'b1, a_item_reg.row_b},
                                 {a_item_reg.col_b, 1'b1, a_item_reg.col_a});
            ld_fend[0] = a_item_reg.col_last;
            ld_rend[0] = 1'b1;
        end else begin
            ld_pend[0] = a_item_reg.row_a && a_item_reg.col_a;
            ld_pend[1] = a_item_reg.row_a && a_item_reg.col_last;
            ld_mask[0] = mk_mask({2'b11, a_item_reg.row_b},
                                 {2'b11, a_item_reg.col_b});
            ld_mask[1] = mk_mask({2'b11, a_item_reg.row_b},
                                 {1'b1, a_item_reg.col_a, 1'b0});
            ld_rend[0] = !ld_pend[1];
            ld_rend[1] = 1'b1;
        end
    end

    // Shift the window when a beat enters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (a_adv) begin
            if (a_item_reg.is_drain) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= rd0_reg[LINE_W-1:bb3_pkg::PIX_W];
                win_reg[2] <= rd1_reg[LINE_W-1:bb3_pkg::PIX_W];
                win_reg[3] <= win_reg[4];
                win_reg[4] <= rd0_reg[bb3_pkg::PIX_W-1:0];
                win_reg[5] <= rd1_reg[bb3_pkg::PIX_W-1:0];
            end else begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i*3]   <= win_reg[i*3+1];
                    win_reg[i*3+1] <= win_reg[i*3+2];
                end
                win_reg[2] <= rd0_reg[LINE_W-1:bb3_pkg::PIX_W];
                win_reg[5] <= rd0_reg[bb3_pkg::PIX_W-1:0];
                win_reg[8] <= a_item_reg.pix;
            end
        end
    end

    // Hold pending result jobs, drop each one as it is dispatched
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'b00;
        end else if (a_adv) begin
            pend_reg <= ld_pend;
        end else if (disp) begin
            pend_reg[sel] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            mask_reg[0] <= ld_mask[0];
            mask_reg[1] <= ld_mask[1];
            fend_reg    <= ld_fend;
            rend_reg    <= ld_rend;
        end
    end

    // Masked channel sums of the window
    assign mask_sel = mask_reg[sel];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_d[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                if (mask_sel[k]) begin
                    sum_d[ch] = sum_d[ch] + bb3_pkg::SUM_W'(win_reg[k][ch*8 +: 8]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_take) begin
            c_valid_reg <= disp;
        end
    end

    always_ff @(posedge aclk) begin
        if (disp) begin
            for (int ch = 0; ch < 3; ch++) begin
                c_sum_reg[ch] <= sum_d[ch];
            end
            c_n_reg    <= bb3_pkg::CNT_W'($countones(mask_sel));
            c_fend_reg <= fend_reg[sel];
            c_rend_reg <= rend_reg[sel];
        end
    end

    // Round half up and divide by the neighbor count
    assign m_recip = bb3_pkg::recip(c_n_reg);
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            rnd[ch]  = c_sum_reg[ch] + bb3_pkg::SUM_W'(c_n_reg >> 1);
            prod[ch] = bb3_pkg::PROD_W'(rnd[ch]) * bb3_pkg::PROD_W'(m_recip);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (d_take) begin
            m_tvalid <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_take && c_valid_reg) begin
            m_tdata <= {prod[2][23:16], prod[1][23:16], prod[0][23:16]};
            m_tlast <= c_fend_reg;
            m_tuser <= c_rend_reg;
        end
    end

`ifndef SYNTH
    a_frame_end_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame end beat without run end");
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> c_n_reg != '0)
        else $error("zero neighbor count");
    a_second_job_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 2'b11 && disp |=> pend_reg == 2'b10)
        else $error("second result lost");
    a_no_shift_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        a_adv |-> pend_reg != 2'b11)
        else $error("window shifted under pending jobs");
`endif

endmodule

// ===== rtl/box_blur_3x3_stream.sv =====
// Top level of the streaming 3x3 box blur.
// RGB pixels enter in raster order, one beat per clock when the output is
// not stalled; each output channel is the rounded-half-up mean of the 3x3
// neighbors that lie inside the frame (divisor 9, 6, 4 or fewer on tiny
// frames). Output (r-1, c-1) leaves after input (r, c); at a row end the
// last column of the previous row leaves too, so such a beat yields two
// results. After the last row, drain beats (tuser = 1) flush it one pixel per
// beat; m_tlast marks the last pixel of the frame and m_tuser the last result
// of an input beat. A result passes through the queue, a registered line-store
// read, the window, then the sum register, whose divide-by-reciprocal
// multiply feeds the output register. The back end issues one result per
// clock while the output is not stalled, so the sustained rate is one beat
// per clock; a row-end beat yields two results, whose extra result the
// four-entry queue hides while the input has gaps, and under unbroken input
// the input stalls once per row. Pixels after a complete frame and drains
// before it are accepted and dropped. Writing a register restarts the frame.
module box_blur_3x3_stream (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [bb3_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // red_in, green_in, blue_in
    input  logic                      s_tuser,   // opcode
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // red_out, green_out, blue_out
    output logic                      m_tlast,   // frame_end
    output logic                      m_tuser    // run_end
);

    logic               push, pop, has_room, q_valid;
    bb3_pkg::bb3_item_t push_item, q_item;

    assign s_tready = has_room;

    bb3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_pix    (s_tdata),
        .in_take   (has_room),
        .push      (push),
        .push_item (push_item)
    );

    bb3_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .has_room  (has_room),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    bb3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/sv/tb_box_blur_3x3_stream.sv =====
// Self-checking testbench for the streaming 3x3 box blur: directed table, then random frames.
module tb_box_blur_3x3_stream;

    // Row kinds of the directed table (beats use OP_PIXEL / OP_DRAIN)
    localparam int ROW_PIXEL = 0;
    localparam int ROW_DRAIN = 1;
    localparam int ROW_CFG   = 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
        logic       run_end;
    } blur_px_t;

    typedef struct {
        int          kind;
        logic        reg_idx;
        int          value;
        logic [23:0] pix;       // blue, green, red from the top bit down
        int          typed_cnt; // -1: use the blur model
        blur_px_t    typed_px;
    } stim_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_addr = 1'b0;
    logic [bb3_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [23:0]               s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [23:0]               m_tdata;
    logic                      m_tlast;
    logic                      m_tuser;

    box_blur_3x3_stream dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #(20 * 600000);
        $display("DONE: errors detected");
        $finish;
    end

    // Blur model state
    logic [23:0] upper_row [bb3_pkg::MAX_WIDTH];
    logic [23:0] middle_row [bb3_pkg::MAX_WIDTH];
    logic [23:0] win [9];
    int unsigned col_cnt, row_cnt, drain_cnt;
    logic [bb3_pkg::WIDTH_W-1:0]  width_reg;
    logic [bb3_pkg::HEIGHT_W-1:0] height_reg;

    blur_px_t blurred_q [$];
    int       errors = 0;
    int       results_seen = 0;
    int       frames_done = 0;
    bit       no_idle = 1'b0;
    bit       hold_req = 1'b0;

    function automatic int unsigned eff_w();
        int unsigned w = width_reg;
        if (w == 0) w = 1;
        if (w > bb3_pkg::MAX_WIDTH) w = bb3_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // Rounded mean of the valid part of a 3x3 block
    function automatic blur_px_t box_mean(input logic [23:0] blk [9], input bit rv [3],
                                          input bit cv [3], input bit fend);
        int unsigned sr = 0, sg = 0, sb = 0, n = 0;
        blur_px_t o;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (rv[i] && cv[j]) begin
                    sr += blk[i*3+j][7:0];
                    sg += blk[i*3+j][15:8];
                    sb += blk[i*3+j][23:16];
                    n++;
                end
        o.red       = 8'((sr + n / 2) / n);
        o.green     = 8'((sg + n / 2) / n);
        o.blue      = 8'((sb + n / 2) / n);
        o.frame_end = fend;
        o.run_end   = 1'b0;
        return o;
    endfunction

    // Advance the model by one accepted beat and queue what it yields
    task automatic blur_accept(input logic op, input logic [23:0] pix);
        int unsigned w, h, c, r, idx, d, col;
        logic [23:0] blk [9];
        bit rv [3];
        bit cv [3];
        blur_px_t outs [$];
        w = eff_w();
        h = eff_h();
        if (op == bb3_pkg::OP_PIXEL) begin
            if (row_cnt >= h || col_cnt >= w) return;
            c = col_cnt;
            r = row_cnt;
            idx = (c < bb3_pkg::MAX_WIDTH) ? c : bb3_pkg::MAX_WIDTH - 1;
            for (int i = 0; i < 3; i++) begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = upper_row[idx];
            win[5] = middle_row[idx];
            win[8] = pix;
            upper_row[idx]  = middle_row[idx];
            middle_row[idx] = pix;
            if (r >= 1) begin
                rv = '{r >= 2, 1'b1, 1'b1};
                if (c >= 1) begin
                    cv = '{c >= 2, 1'b1, 1'b1};
                    outs.push_back(box_mean(win, rv, cv, 1'b0));
                end
                if (c == w - 1) begin
                    cv = '{1'b0, c >= 1, 1'b1};
                    outs.push_back(box_mean(win, rv, cv, 1'b0));
                end
            end
            col_cnt = c + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt = r + 1;
            end
        end else begin
            if (row_cnt < h) return;
            d = (drain_cnt >= w) ? w - 1 : drain_cnt;
            for (int j = 0; j < 9; j++) blk[j] = '0;
            for (int j = 0; j < 3; j++) begin
                col = d + j;
                if (col >= 1 && col - 1 < w) begin
                    blk[j]   = upper_row[col-1];
                    blk[3+j] = middle_row[col-1];
                end
            end
            rv = '{h >= 2, 1'b1, 1'b0};
            cv = '{d >= 1, 1'b1, d + 1 < w};
            outs.push_back(box_mean(blk, rv, cv, d == w - 1));
            drain_cnt = d + 1;
            if (drain_cnt >= w) begin
                drain_cnt = 0;
                col_cnt = 0;
                row_cnt = 0;
                frames_done++;
            end
        end
        if (outs.size() > 0) outs[outs.size()-1].run_end = 1'b1;
        foreach (outs[k]) blurred_q.push_back(outs[k]);
    endtask

    // Send one beat; returns once it has been accepted
    task automatic send_beat(input logic op, input logic [23:0] pix);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_gap();
        int g, p;
        if (no_idle) return;
        p = $urandom_range(99);
        g = (p < 65) ? 0 : (p < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Drive a beat whose results come from the blur model
    task automatic push_beat(input logic op, input logic [23:0] pix);
        send_beat(op, pix);
        blur_accept(op, pix);
        sender_gap();
    endtask

    // Drain the pipe, then write one register while the block is idle
    task automatic write_reg(input logic idx, input int value);
        s_tvalid <= 1'b0;
        wait (blurred_q.size() == 0);
        repeat (12) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[bb3_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == bb3_pkg::REG_WIDTH) width_reg = value[bb3_pkg::WIDTH_W-1:0];
        else height_reg = value[bb3_pkg::HEIGHT_W-1:0];
        col_cnt = 0;
        row_cnt = 0;
        drain_cnt = 0;
    endtask

    function automatic logic [23:0] rand_pix();
        logic [23:0] p;
        p = 24'($urandom);
        case ($urandom_range(9))
            0: p = '0;
            1: p = '1;
            default: ;
        endcase
        return p;
    endfunction

    // One frame with random content, optional noise, optional early cutoff
    task automatic run_frame(input int w, input int h, input bit noisy);
        int wn, hn, cut;
        write_reg(bb3_pkg::REG_WIDTH, w);
        write_reg(bb3_pkg::REG_HEIGHT, h);
        wn = eff_w();
        hn = eff_h();
        cut = ($urandom_range(9) == 0) ? $urandom_range(0, wn * hn) : -1;
        for (int i = 0; i < wn * hn; i++) begin
            if (i == cut) return;
            if (noisy && $urandom_range(19) == 0) push_beat(bb3_pkg::OP_DRAIN, rand_pix());
            push_beat(bb3_pkg::OP_PIXEL, rand_pix());
        end
        if (noisy && $urandom_range(9) == 0) push_beat(bb3_pkg::OP_PIXEL, rand_pix());
        for (int i = 0; i < wn; i++) push_beat(bb3_pkg::OP_DRAIN, rand_pix());
    endtask

    // Receiver: random backpressure, one long hold on request
    int hold_left = 0;
    int stall_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            results_seen++;
            if (blurred_q.size() == 0) begin
                $error("unexpected result beat: data=%h last=%b user=%b",
                       m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                blurred_px_check(blurred_q.pop_front());
            end
        end
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (no_idle || $urandom_range(99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
    end

    task automatic blurred_px_check(input blur_px_t e);
        if (m_tdata[7:0] !== e.red) begin
            $error("red_out: expected %0d, got %0d", e.red, m_tdata[7:0]);
            errors++;
        end
        if (m_tdata[15:8] !== e.green) begin
            $error("green_out: expected %0d, got %0d", e.green, m_tdata[15:8]);
            errors++;
        end
        if (m_tdata[23:16] !== e.blue) begin
            $error("blue_out: expected %0d, got %0d", e.blue, m_tdata[23:16]);
            errors++;
        end
        if (m_tlast !== e.frame_end) begin
            $error("frame_end: expected %b, got %b", e.frame_end, m_tlast);
            errors++;
        end
        if (m_tuser !== e.run_end) begin
            $error("run_end: expected %b, got %b", e.run_end, m_tuser);
            errors++;
        end
    endtask

    stim_row_t dir_tab [$];

    function automatic stim_row_t mk(input int kind, input logic idx, input int value,
                                     input logic [23:0] pix, input int cnt,
                                     input blur_px_t px);
        stim_row_t s;
        s.kind = kind; s.reg_idx = idx; s.value = value; s.pix = pix;
        s.typed_cnt = cnt; s.typed_px = px;
        return s;
    endfunction

    initial begin
        int rand_items;
        for (int i = 0; i < bb3_pkg::MAX_WIDTH; i++) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        col_cnt = 0; row_cnt = 0; drain_cnt = 0;
        width_reg = 640; height_reg = 480;

        // Directed: early drain, 1x1 frame, ignored pixel, 3x3 extremes, 2x2 frame
        dir_tab.push_back(mk(ROW_DRAIN, 1'b0, 0, 24'h123456, 0, '0));
        dir_tab.push_back(mk(ROW_CFG, bb3_pkg::REG_WIDTH, 1, 24'h0, -1, '0));
        dir_tab.push_back(mk(ROW_CFG, bb3_pkg::REG_HEIGHT, 1, 24'h0, -1, '0));
        dir_tab.push_back(mk(ROW_DRAIN, 1'b0, 0, 24'hffffff, 0, '0));
        dir_tab.push_back(mk(ROW_PIXEL, 1'b0, 0, 24'h8000ff, 0, '0));
        dir_tab.push_back(mk(ROW_PIXEL, 1'b0, 0, 24'h777777, 0, '0));
        dir_tab.push_back(mk(ROW_DRAIN, 1'b0, 0, 24'h000000, 1,
                             '{8'hff, 8'h00, 8'h80, 1'b1, 1'b1}));
        dir_tab.push_back(mk(ROW_CFG, bb3_pkg::REG_WIDTH, 3, 24'h0, -1, '0));
        dir_tab.push_back(mk(ROW_CFG, bb3_pkg::REG_HEIGHT, 3, 24'h0, -1, '0));
        for (int i = 0; i < 9; i++)
            dir_tab.push_back(mk(ROW_PIXEL, 1'b0, 0, (i % 2) ? 24'h000000 : 24'hffffff,
                                 -1, '0));
        for (int i = 0; i < 3; i++) dir_tab.push_back(mk(ROW_DRAIN, 1'b0, 0, 24'h0, -1, '0));
        dir_tab.push_back(mk(ROW_CFG, bb3_pkg::REG_WIDTH, 2, 24'h0, -1, '0));
        dir_tab.push_back(mk(ROW_CFG, bb3_pkg::REG_HEIGHT, 2, 24'h0, -1, '0));
        for (int i = 0; i < 4; i++)
            dir_tab.push_back(mk(ROW_PIXEL, 1'b0, 0, 24'hfefefe, -1, '0));
        for (int i = 0; i < 2; i++) dir_tab.push_back(mk(ROW_DRAIN, 1'b0, 0, 24'h0, 1,
                                     '{8'hfe, 8'hfe, 8'hfe, i == 1, 1'b1}));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                write_reg(dir_tab[k].reg_idx, dir_tab[k].value);
            end else begin
                logic op;
                int before_cnt;
                op = (dir_tab[k].kind == ROW_DRAIN) ? bb3_pkg::OP_DRAIN : bb3_pkg::OP_PIXEL;
                send_beat(op, dir_tab[k].pix);
                if (dir_tab[k].typed_cnt < 0) begin
                    blur_accept(op, dir_tab[k].pix);
                end else begin
                    // keep the model in step, but expect the values written above
                    before_cnt = blurred_q.size();
                    blur_accept(op, dir_tab[k].pix);
                    while (blurred_q.size() > before_cnt) void'(blurred_q.pop_back());
                    if (dir_tab[k].typed_cnt > 0) blurred_q.push_back(dir_tab[k].typed_px);
                end
                sender_gap();
            end
        end

        // Register extremes: zero width and height, then one tall and one wide strip
        run_frame(0, 0, 1'b0);
        run_frame(1, 64, 1'b0);
        run_frame(64, 1, 1'b0);

        // Long receiver hold while the sender streams without gaps
        no_idle = 1'b0;
        write_reg(bb3_pkg::REG_WIDTH, 40);
        write_reg(bb3_pkg::REG_HEIGHT, 6);
        no_idle = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 240; i++) push_beat(bb3_pkg::OP_PIXEL, rand_pix());
        for (int i = 0; i < 40; i++) push_beat(bb3_pkg::OP_DRAIN, rand_pix());
        no_idle = 1'b0;

        // Random frames, mostly small
        rand_items = 0;
        while (rand_items < 750) begin
            int w, h;
            no_idle = ($urandom_range(4) == 0);
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            run_frame(w, h, 1'b1);
            rand_items += w * h + w;
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        wait (blurred_q.size() == 0);
        repeat (30) @(posedge aclk);
        $display("Covered %0d complete frames and %0d result beats on frames from 1x1",
                 frames_done, results_seen);
        $display("up to 64 pixels on a side, with noise beats, cut frames and a long stall.");
        if (errors == 0 && blurred_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
